// ===== rtl/ghi_pkg.sv =====
// ghi_pkg: shared types and constants for the gre header inserter
// no dependencies; imported by every module of the block
`default_nettype none

package ghi_pkg;

    localparam int MAX_RESULTS         = 5;
    localparam int POSITION_BITS_DEF   = 16;
    localparam int LINK_OFFSET_BITS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF     = 4;

    localparam int COUNT_BITS = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0]  GRE_PROTO_NUM = 8'd47;
    localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6    = 16'h86DD;
    localparam logic [15:0] LEN_GROWTH    = 16'd4;
    localparam logic [15:0] CSUM_KEEP     = 16'hffff;

    localparam logic [5:0] IPV4_HDR_LEN = 6'd20;
    localparam logic [5:0] IPV6_HDR_LEN = 6'd40;

    // byte offsets inside the outer ip header
    localparam logic [5:0] REL_V4_LEN_HI  = 6'd2;
    localparam logic [5:0] REL_V4_LEN_LO  = 6'd3;
    localparam logic [5:0] REL_V4_TTL     = 6'd8;
    localparam logic [5:0] REL_V4_PROTO   = 6'd9;
    localparam logic [5:0] REL_V4_CSUM_HI = 6'd10;
    localparam logic [5:0] REL_V4_CSUM_LO = 6'd11;
    localparam logic [5:0] REL_V6_LEN_HI  = 6'd4;
    localparam logic [5:0] REL_V6_LEN_LO  = 6'd5;
    localparam logic [5:0] REL_V6_NEXT    = 6'd6;

    // bytes caused by one input item
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [COUNT_BITS-1:0]       count;
        logic                        pkt_last;
    } t_entry;

    typedef struct packed {
        logic valid;
        logic full;
    } t_queue_status;

endpackage

`default_nettype wire

// ===== rtl/ghi_front.sv =====
// ghi_front: accepts packet bytes, tracks header position and rewrites fields
// depends on ghi_pkg; produces at most one t_entry per accepted item, none for a held byte
`default_nettype none

module ghi_front
    import ghi_pkg::*;
#(
    parameter int POSITION_BITS    = POSITION_BITS_DEF,
    parameter int LINK_OFFSET_BITS = LINK_OFFSET_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_first_byte,
    input  wire logic       i_last_byte,
    input  wire logic [7:0] i_link_header_len,
    input  wire logic       i_outer_is_ipv6,
    input  wire logic       i_inner_is_ipv4,
    output logic            o_push,
    output t_entry          o_entry
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [POSITION_BITS-1:0]    r_pos, n_pos;
    logic [LINK_OFFSET_BITS-1:0] r_hs, n_hs;
    logic                        r_v6, n_v6;
    logic                        r_v4i, n_v4i;
    logic [7:0]                  r_held, n_held;
    logic [15:0]                 r_delta, n_delta;

    logic [POSITION_BITS-1:0]    pos_eff, hs_ext, diff;
    logic [LINK_OFFSET_BITS-1:0] hs_eff;
    logic                        v6_eff, v4i_eff;
    logic [15:0]                 delta_eff, w, nw, csum, etype;
    logic [5:0]                  iplen, rel;
    logic                        in_hdr, hold;
    t_entry                      ent;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [15:0] r;
        s = {1'b0, a} + {1'b0, b};
        r = s[15:0] + {15'd0, s[16]};
        return r;
    endfunction

    always_comb begin
        hs_eff    = i_first_byte ? LINK_OFFSET_BITS'(i_link_header_len) : r_hs;
        v6_eff    = i_first_byte ? i_outer_is_ipv6 : r_v6;
        v4i_eff   = i_first_byte ? i_inner_is_ipv4 : r_v4i;
        pos_eff   = i_first_byte ? '0 : r_pos;
        delta_eff = i_first_byte ? '0 : r_delta;

        iplen  = v6_eff ? IPV6_HDR_LEN : IPV4_HDR_LEN;
        hs_ext = POSITION_BITS'(hs_eff);
        diff   = pos_eff - hs_ext;
        in_hdr = (pos_eff >= hs_ext) && (diff < POSITION_BITS'(iplen));
        rel    = diff[5:0];

        w     = {r_held, i_data_byte};
        nw    = w + LEN_GROWTH;
        csum  = oc_add(~w, delta_eff);
        if (csum != CSUM_KEEP) begin
            csum = ~csum;
        end
        etype = v4i_eff ? ETYPE_IPV4 : ETYPE_IPV6;

        n_hs    = hs_eff;
        n_v6    = v6_eff;
        n_v4i   = v4i_eff;
        n_held  = r_held;
        n_delta = delta_eff;
        hold    = 1'b0;

        ent          = '0;
        ent.bytes[0] = i_data_byte;
        ent.count    = COUNT_BITS'(1);
        ent.pkt_last = i_last_byte;

        if (in_hdr) begin
            if (v6_eff) begin
                if (rel == REL_V6_LEN_HI) begin
                    hold = 1'b1;
                end else if (rel == REL_V6_LEN_LO) begin
                    ent.bytes[0] = nw[15:8];
                    ent.bytes[1] = nw[7:0];
                    ent.count    = COUNT_BITS'(2);
                end else if (rel == REL_V6_NEXT) begin
                    ent.bytes[0] = GRE_PROTO_NUM;
                end
            end else begin
                if (rel == REL_V4_LEN_HI || rel == REL_V4_CSUM_HI) begin
                    hold = 1'b1;
                end else if (rel == REL_V4_LEN_LO) begin
                    n_delta      = oc_add(oc_add(delta_eff, ~w), nw);
                    ent.bytes[0] = nw[15:8];
                    ent.bytes[1] = nw[7:0];
                    ent.count    = COUNT_BITS'(2);
                end else if (rel == REL_V4_TTL) begin
                    n_held = i_data_byte;
                end else if (rel == REL_V4_PROTO) begin
                    n_delta      = oc_add(oc_add(delta_eff, ~w), {r_held, GRE_PROTO_NUM});
                    ent.bytes[0] = GRE_PROTO_NUM;
                end else if (rel == REL_V4_CSUM_LO) begin
                    ent.bytes[0] = csum[15:8];
                    ent.bytes[1] = csum[7:0];
                    ent.count    = COUNT_BITS'(2);
                end
            end

            // a held high byte at packet end passes through unchanged
            if (hold) begin
                if (!i_last_byte) begin
                    n_held    = i_data_byte;
                    ent.count = '0;
                end
            end

            if (rel == iplen - 6'd1) begin
                ent.bytes[1] = 8'h00;
                ent.bytes[2] = 8'h00;
                ent.bytes[3] = etype[15:8];
                ent.bytes[4] = etype[7:0];
                ent.count    = COUNT_BITS'(MAX_RESULTS);
            end
        end

        if (i_last_byte) begin
            n_pos   = '0;
            n_delta = '0;
        end else if (pos_eff != POS_MAX) begin
            n_pos = pos_eff + POSITION_BITS'(1);
        end else begin
            n_pos = pos_eff;
        end
    end

    assign o_push  = i_accept && (ent.count != '0);
    assign o_entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_hs    <= '0;
            r_v6    <= 1'b0;
            r_v4i   <= 1'b0;
            r_held  <= '0;
            r_delta <= '0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_hs    <= n_hs;
            r_v6    <= n_v6;
            r_v4i   <= n_v4i;
            r_held  <= n_held;
            r_delta <= n_delta;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ghi_queue.sv =====
// ghi_queue: short fifo of t_entry between front and back
// depends on ghi_pkg
`default_nettype none

module ghi_queue
    import ghi_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_entry  i_entry,
    input  wire logic    i_pop,
    output t_entry       o_entry,
    output t_queue_status o_status
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    assign o_entry         = r_mem[r_rd_ptr];
    assign o_status.valid  = (r_count != '0);
    assign o_status.full   = (r_count == CNT_BITS'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_BITS'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_BITS'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_BITS'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ghi_back.sv =====
// ghi_back: walks the bytes of the head entry into the output register
// depends on ghi_pkg
`default_nettype none

module ghi_back
    import ghi_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_entry        i_entry,
    input  wire t_queue_status i_status,
    output logic               o_pop,
    input  wire logic          i_out_stall,
    output logic               o_out_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_run_last,
    output logic               o_packet_last
);

    logic [COUNT_BITS-1:0] r_idx;
    logic                  r_out_valid;
    logic [7:0]            r_out_byte;
    logic                  r_run_last, r_packet_last;
    logic                  load, fin;

    assign load  = i_status.valid && (!r_out_valid || !i_out_stall);
    assign fin   = (r_idx == i_entry.count - COUNT_BITS'(1));
    assign o_pop = load && fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else if (load) begin
            r_out_valid <= 1'b1;
            r_idx       <= fin ? '0 : r_idx + COUNT_BITS'(1);
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte    <= i_entry.bytes[r_idx];
            r_run_last    <= fin;
            r_packet_last <= fin && i_entry.pkt_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_run_last    = r_run_last;
    assign o_packet_last = r_packet_last;

endmodule

`default_nettype wire

// ===== rtl/gre_header_inserter.sv =====
// gre_header_inserter: top level, front classifier, entry queue and byte back end
// depends on ghi_pkg, ghi_front, ghi_queue, ghi_back
//
// channel  | valid       | stall        | payload
// ---------+-------------+--------------+-----------------------------------------------
// input    | i_in_valid  | o_in_stall   | i_data_byte, i_first_byte, i_last_byte,
//          |             |              | i_link_header_len, i_outer_is_ipv6, i_inner_is_ipv4
// output   | o_out_valid | i_out_stall  | o_out_byte, o_run_last, o_packet_last
//
// one input item per cycle is taken while the entry queue has room
// the back end sends one output byte per cycle unless stalled; an item gives 0 to 5 bytes,
// so after a gre insertion (5 bytes) the queue of QUEUE_DEPTH entries absorbs the burst
// a taken item is written to the queue, then its first byte to the output register
// synchronous active-low reset clears position, flags, queue and output valid
`default_nettype none

module gre_header_inserter
    import ghi_pkg::*;
#(
    parameter int POSITION_BITS    = POSITION_BITS_DEF,
    parameter int LINK_OFFSET_BITS = LINK_OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_first_byte,
    input  wire logic       i_last_byte,
    input  wire logic [7:0] i_link_header_len,
    input  wire logic       i_outer_is_ipv6,
    input  wire logic       i_inner_is_ipv4,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last,
    output logic            o_packet_last
);

    logic          accept, push, pop;
    t_entry        push_entry, head_entry;
    t_queue_status q_status;

    assign o_in_stall = q_status.full;
    assign accept     = i_in_valid && !q_status.full;

    ghi_front #(
        .POSITION_BITS    (POSITION_BITS),
        .LINK_OFFSET_BITS (LINK_OFFSET_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_data_byte       (i_data_byte),
        .i_first_byte      (i_first_byte),
        .i_last_byte       (i_last_byte),
        .i_link_header_len (i_link_header_len),
        .i_outer_is_ipv6   (i_outer_is_ipv6),
        .i_inner_is_ipv4   (i_inner_is_ipv4),
        .o_push            (push),
        .o_entry           (push_entry)
    );

    ghi_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    ghi_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (head_entry),
        .i_status      (q_status),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_packet_last (o_packet_last)
    );

endmodule

`default_nettype wire
